FILE: hdl/sfc_pkg.sv
// Shared constants and width helpers for the sphere frustum cull core.
// Used by sfc_plane_eval and sphere_frustum_cull_core; depends on nothing.
`timescale 1ns / 1ps

package sfc_pkg;

    localparam int NUM_PLANES      = 6;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int COEF_WIDTH      = 16;
    localparam int FRAC_BITS       = 14;
    localparam int RADIUS_WIDTH    = 15;
    localparam int BOUND_R_WIDTH   = 16;
    localparam int OFF_W           = 18;
    localparam int OFFSET_CAP      = 131072;
    localparam int CFG_ADDR_WIDTH  = 6;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int REG_IDX_WIDTH   = 3;

    localparam logic [REG_IDX_WIDTH-1:0] REG_BOUND_CENTER = 3'd6;
    localparam logic [REG_IDX_WIDTH-1:0] REG_BOUND_SPHERE = 3'd7;

    localparam logic [1:0] VIEW_OUTSIDE = 2'd0;
    localparam logic [1:0] VIEW_PARTIAL = 2'd1;
    localparam logic [1:0] VIEW_INSIDE  = 2'd2;

    // Width of one coefficient-by-coordinate product.
    function automatic int prod_width(input int cw);
        return COEF_WIDTH + cw;
    endfunction

    // Width of a full plane distance: three products plus d scaled by 2^14.
    function automatic int dist_width(input int cw);
        int w;
        w = prod_width(cw);
        if (w < COEF_WIDTH + FRAC_BITS)
            w = COEF_WIDTH + FRAC_BITS;
        return w + 2;
    endfunction

endpackage

FILE: hdl/sfc_plane_eval.sv
// One plane of the view volume: registered products, then registered distance.
// Depends on sfc_pkg.
`timescale 1ns / 1ps

module sfc_plane_eval
    import sfc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                                   clk,
    input  logic signed [COORD_WIDTH-1:0]          x,
    input  logic signed [COORD_WIDTH-1:0]          y,
    input  logic signed [COORD_WIDTH-1:0]          z,
    input  logic        [4*COEF_WIDTH-1:0]         plane,
    output logic signed [dist_width(COORD_WIDTH)-1:0] distance
);

    localparam int PROD_W = prod_width(COORD_WIDTH);
    localparam int DIST_W = dist_width(COORD_WIDTH);

    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;
    logic signed [COEF_WIDTH-1:0] coef_d;

    logic signed [PROD_W-1:0] pa_next, pb_next, pc_next;
    logic signed [PROD_W-1:0] pa_reg, pb_reg, pc_reg;
    logic signed [DIST_W-1:0] dist_next;
    logic signed [DIST_W-1:0] dist_reg;

    assign coef_a = plane[COEF_WIDTH-1:0];
    assign coef_b = plane[2*COEF_WIDTH-1:COEF_WIDTH];
    assign coef_c = plane[3*COEF_WIDTH-1:2*COEF_WIDTH];
    assign coef_d = plane[4*COEF_WIDTH-1:3*COEF_WIDTH];

    assign pa_next = PROD_W'(coef_a) * PROD_W'(x);
    assign pb_next = PROD_W'(coef_b) * PROD_W'(y);
    assign pc_next = PROD_W'(coef_c) * PROD_W'(z);

    // d is in world units, lined up with the products of Q2.14 coefficients.
    assign dist_next = DIST_W'(pa_reg) + DIST_W'(pb_reg) + DIST_W'(pc_reg)
                     + (DIST_W'(coef_d) <<< FRAC_BITS);

    always_ff @(posedge clk)
    begin
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        pc_reg   <= pc_next;
        dist_reg <= dist_next;
    end

    assign distance = dist_reg;

endmodule

FILE: hdl/sphere_frustum_cull_core.sv
// Sphere against six-plane view volume classifier, with an optional bounding-sphere pretest.
// Depends on sfc_pkg and sfc_plane_eval.
// The start strobe passes through v_s1_reg, v_s2_reg and v_s3_reg into done_reg; view_state is registered with done.
// Throughput: one sphere per cycle; busy is always low and results cannot be stalled.
// The four-stage pipeline is set by the plane multipliers and the distance adders.
// Reset clears all configuration registers to zero and empties the pipeline.
`timescale 1ns / 1ps

module sphere_frustum_cull_core
    import sfc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CFG_ADDR_WIDTH-1:0]     paddr,
    input  logic [CFG_DATA_WIDTH-1:0]     pwdata,
    output logic [CFG_DATA_WIDTH-1:0]     prdata,
    output logic                          pready,

    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] center_z,
    input  logic [RADIUS_WIDTH-1:0]       radius,

    output logic                          done,
    output logic [1:0]                    view_state
);

    localparam int DIST_W  = dist_width(COORD_WIDTH);
    localparam int DIFF_W  = ((COORD_WIDTH > COEF_WIDTH) ? COORD_WIDTH : COEF_WIDTH) + 1;
    localparam int MAG_W   = (DIFF_W > OFF_W) ? DIFF_W : OFF_W;
    localparam int RS_W    = BOUND_R_WIDTH + 1;
    localparam int SQ_W    = 2 * OFF_W;
    localparam int SQSUM_W = SQ_W + 2;
    localparam int RS2_W   = 2 * RS_W;
    localparam int LIM_W   = RADIUS_WIDTH + FRAC_BITS;
    localparam int BC_W    = 3 * COEF_WIDTH;
    localparam int BS_W    = BOUND_R_WIDTH + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DATA_WIDTH-1:0] plane_reg [NUM_PLANES];
    logic [BC_W-1:0]           bound_center_reg;
    logic [BS_W-1:0]           bound_sphere_reg;
    logic [REG_IDX_WIDTH-1:0]  cfg_idx;
    logic                      cfg_write;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[CFG_ADDR_WIDTH-1:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                plane_reg[i] <= '0;
            end
            bound_center_reg <= '0;
            bound_sphere_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_idx == REG_BOUND_CENTER)
                bound_center_reg <= pwdata[BC_W-1:0];
            else if (cfg_idx == REG_BOUND_SPHERE)
                bound_sphere_reg <= pwdata[BS_W-1:0];
            else
                plane_reg[cfg_idx] <= pwdata;
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_BOUND_CENTER: prdata = CFG_DATA_WIDTH'(bound_center_reg);
            REG_BOUND_SPHERE: prdata = CFG_DATA_WIDTH'(bound_sphere_reg);
            default:          prdata = plane_reg[cfg_idx];
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the word, pretest offsets with saturation
    // ------------------------------------------------------------------
    logic                          accept;
    logic                          v_s1_reg, v_s2_reg, v_s3_reg;
    logic signed [COORD_WIDTH-1:0] x_s1_reg, y_s1_reg, z_s1_reg;
    logic [RADIUS_WIDTH-1:0]       r_s1_reg, r_s2_reg;
    logic [OFF_W-1:0]              ax_next, ay_next, az_next;
    logic [OFF_W-1:0]              ax_s1_reg, ay_s1_reg, az_s1_reg;
    logic [RS_W-1:0]               rs_next, rs_s1_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    function automatic logic [OFF_W-1:0] capped_offset(
        input logic signed [COORD_WIDTH-1:0] c,
        input logic signed [COEF_WIDTH-1:0]  b
    );
        logic signed [MAG_W:0] diff;
        logic [MAG_W-1:0]      mag;
        diff = (MAG_W+1)'(c) - (MAG_W+1)'(b);
        mag  = diff[MAG_W] ? MAG_W'(-diff) : MAG_W'(diff);
        if (mag > MAG_W'(OFFSET_CAP))
            return OFF_W'(OFFSET_CAP);
        return mag[OFF_W-1:0];
    endfunction

    assign ax_next = capped_offset(center_x, bound_center_reg[COEF_WIDTH-1:0]);
    assign ay_next = capped_offset(center_y, bound_center_reg[2*COEF_WIDTH-1:COEF_WIDTH]);
    assign az_next = capped_offset(center_z, bound_center_reg[3*COEF_WIDTH-1:2*COEF_WIDTH]);
    assign rs_next = RS_W'(radius) + RS_W'(bound_sphere_reg[BOUND_R_WIDTH-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s1_reg <= 1'b0;
            v_s2_reg <= 1'b0;
            v_s3_reg <= 1'b0;
        end
        else
        begin
            v_s1_reg <= accept;
            v_s2_reg <= v_s1_reg;
            v_s3_reg <= v_s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_s1_reg  <= center_x;
        y_s1_reg  <= center_y;
        z_s1_reg  <= center_z;
        r_s1_reg  <= radius;
        ax_s1_reg <= ax_next;
        ay_s1_reg <= ay_next;
        az_s1_reg <= az_next;
        rs_s1_reg <= rs_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: squares; plane products live in the plane units
    // Stage 3: sums; plane distances live in the plane units
    // ------------------------------------------------------------------
    logic [SQ_W-1:0]    sqx_s2_reg, sqy_s2_reg, sqz_s2_reg;
    logic [RS2_W-1:0]   rs2_s2_reg, rs2_s3_reg;
    logic [SQSUM_W-1:0] sqsum_next, sqsum_s3_reg;
    logic [LIM_W-1:0]   lim_next, lim_s3_reg;

    assign sqsum_next = SQSUM_W'(sqx_s2_reg) + SQSUM_W'(sqy_s2_reg) + SQSUM_W'(sqz_s2_reg);
    assign lim_next   = LIM_W'(r_s2_reg) << FRAC_BITS;

    always_ff @(posedge clk)
    begin
        sqx_s2_reg   <= SQ_W'(ax_s1_reg) * SQ_W'(ax_s1_reg);
        sqy_s2_reg   <= SQ_W'(ay_s1_reg) * SQ_W'(ay_s1_reg);
        sqz_s2_reg   <= SQ_W'(az_s1_reg) * SQ_W'(az_s1_reg);
        rs2_s2_reg   <= RS2_W'(rs_s1_reg) * RS2_W'(rs_s1_reg);
        r_s2_reg     <= r_s1_reg;
        sqsum_s3_reg <= sqsum_next;
        rs2_s3_reg   <= rs2_s2_reg;
        lim_s3_reg   <= lim_next;
    end

    logic signed [DIST_W-1:0] dist_s3 [NUM_PLANES];

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        sfc_plane_eval #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_plane (
            .clk      (clk),
            .x        (x_s1_reg),
            .y        (y_s1_reg),
            .z        (z_s1_reg),
            .plane    (plane_reg[p]),
            .distance (dist_s3[p])
        );
    end

    // ------------------------------------------------------------------
    // Stage 4: compares and classification into the result register
    // ------------------------------------------------------------------
    logic signed [DIST_W-1:0] pos_lim;
    logic signed [DIST_W-1:0] neg_lim;
    logic [NUM_PLANES-1:0]    out_hit;
    logic [NUM_PLANES-1:0]    part_hit;
    logic                     pretest_out;
    logic [1:0]               view_next;
    logic [1:0]               view_reg;
    logic                     done_reg;

    assign pos_lim = $signed({{(DIST_W-LIM_W){1'b0}}, lim_s3_reg});
    assign neg_lim = -pos_lim;

    always_comb
    begin
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            out_hit[i]  = (dist_s3[i] <= neg_lim);
            part_hit[i] = (dist_s3[i] <= pos_lim);
        end
    end

    // A sphere that merely touches the bounding sphere still passes the pretest.
    assign pretest_out = bound_sphere_reg[BOUND_R_WIDTH]
                         && (SQSUM_W'(rs2_s3_reg) < sqsum_s3_reg);

    always_comb
    begin
        if (pretest_out || (|out_hit))
            view_next = VIEW_OUTSIDE;
        else if (|part_hit)
            view_next = VIEW_PARTIAL;
        else
            view_next = VIEW_INSIDE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v_s3_reg;
    end

    always_ff @(posedge clk)
    begin
        view_reg <= view_next;
    end

    assign done       = done_reg;
    assign view_state = view_reg;

endmodule
